/* design/energy_voice_activity_detector_core_defines.svh */
// Assertion macros shared by the voice activity detector RTL.
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_DEFINES_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every clock outside reset
`define EVAD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("evad assertion failed");
// Next-cycle implication, checked on every clock outside reset
`define EVAD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("evad assertion failed");
`else
`define EVAD_ASSERT_IMP(lbl, ante, cons)
`define EVAD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* design/evad_pkg.sv */
// Types, widths and codes for the energy voice activity detector.
package evad_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int EVENT_W    = 3;
    localparam int THR_W      = 16;
    localparam int MS_W       = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int SUM_W  = 42;
    localparam int DIVD_W = SUM_W + 2;
    localparam int REM_W  = DIVD_W / 2 + 4;
    localparam int CNTR_W = 20;
    localparam int K_W    = 30;
    localparam int TH_W   = 20;
    localparam int NUM_W  = 21;

    // Arithmetic constants
    localparam int MS_PER_S   = 1000;
    localparam int FLOOR_DIV  = 20;
    localparam int FLOOR_KEEP = 19;
    localparam int FLOOR_BIAS = 10;
    localparam int ACT_MUL    = 3;
    localparam int ACT_FLR    = 10;
    localparam int REL_MUL    = 3;
    localparam int REL_FLR    = 6;

    // Reset values of the registers
    localparam logic [THR_W-1:0] ACT_RST = THR_W'(1311);
    localparam logic [THR_W-1:0] REL_RST = THR_W'(655);
    localparam int SIL_MS_RST = 800;
    localparam int MIN_MS_RST = 250;
    localparam int MAX_MS_RST = 30000;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_SILENCE  = EVENT_W'(0);
    localparam logic [EVENT_W-1:0] EV_START    = EVENT_W'(1);
    localparam logic [EVENT_W-1:0] EV_SPEAKING = EVENT_W'(2);
    localparam logic [EVENT_W-1:0] EV_END      = EVENT_W'(3);
    localparam logic [EVENT_W-1:0] EV_ABORT    = EVENT_W'(4);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REL = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SIL = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX = CFG_IDX_W'(4);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_last;
    } t_in_beat;

    typedef struct packed {
        logic [EVENT_W-1:0] vad_event;
        logic [LEVEL_W-1:0] frame_level;
        logic               frame_overflow;
    } t_out_beat;

    // Divide / root unit control and status
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_du_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_du_stat;

endpackage

/* design/energy_voice_activity_detector_core.sv */
// Top level of the energy voice activity detector with hysteresis.
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+-------------------------------
//  in      | sink      | i_in_valid / o_in_stall | sample, frame_last
//  out     | source    | o_out_valid/i_out_stall | vad_event, frame_level, overflow
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A sample that does not close a frame is squared and then accumulated. A closing
// sample also goes through the mean square division and the root, then a decision
// that starts speech, seeds an empty floor, checks the length limit, silence
// timeout and minimum length while speaking, or averages the noise floor: the
// shared divide / root unit runs 44 steps for the mean square, 22 for the root and
// 44 more for the floor average. Reset is synchronous, active low; a sample can be
// taken as soon as it is released. The result sits in an output register, so a
// stalled result does not block the next frame's samples; only the final emit step
// waits on a full register for as long as the waiting result stays stalled.
`include "energy_voice_activity_detector_core_defines.svh"
module energy_voice_activity_detector_core #(
    parameter int SAMPLE_RATE = 16000,
    parameter int MAX_FRAME   = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  evad_pkg::t_in_beat              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output evad_pkg::t_out_beat             o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [evad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import evad_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int LIM_W = $clog2(64'(SAMPLE_RATE) * 64'd65536);
    localparam int CMP_W = (LIM_W > K_W) ? LIM_W : K_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_DIV, S_SQRT, S_DECIDE, S_FLOOR,
        S_PMAX, S_CMAX, S_CSIL, S_CMIN, S_EMIT
    } t_state;

    // Configuration, durations kept as ms * SAMPLE_RATE
    logic [THR_W-1:0] r_act_thr;
    logic [THR_W-1:0] r_rel_thr;
    logic [LIM_W-1:0] r_sil_lim;
    logic [LIM_W-1:0] r_min_lim;
    logic [LIM_W-1:0] r_max_lim;

    // Sequencer and detector state
    t_state             r_state;
    logic [SQ_W-1:0]    r_sq;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_over;
    logic               r_take;
    logic               r_last;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] r_floor;
    logic               r_speaking;
    logic [CNTR_W-1:0]  r_sil;
    logic [CNTR_W-1:0]  r_spk;
    logic [CNTR_W-1:0]  r_spoken;
    logic               r_quiet;
    logic [K_W-1:0]     r_k;
    logic [EVENT_W-1:0] r_ev;
    logic               r_out_valid;
    t_out_beat          r_out;

    // Shared unit hookup
    t_du_cmd            du_cmd;
    t_du_stat           du_stat;
    logic [DIVD_W-1:0]  du_dividend;
    logic [CNT_W-1:0]   du_divisor;
    logic [DIVD_W-1:0]  du_res;

    logic [SAMPLE_W-1:0] in_raw;
    logic [SAMPLE_W-1:0] in_mag;
    logic [SUM_W:0]      sum_ext;
    logic [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]    acc_sum;
    logic [TH_W-1:0]     lv4;
    logic [TH_W-1:0]     act_a;
    logic [TH_W-1:0]     act_b;
    logic [TH_W-1:0]     rel_a;
    logic [TH_W-1:0]     rel_b;
    logic                loud;
    logic                quiet;
    logic [CNTR_W:0]     spk_ext;
    logic [CNTR_W:0]     sil_ext;
    logic [CNTR_W-1:0]   n_spk;
    logic [CNTR_W-1:0]   n_sil;
    logic [CNTR_W-1:0]   spoken;
    logic [NUM_W-1:0]    floor_num;
    logic [CNTR_W-1:0]   mul_src;
    logic [K_W-1:0]      k_val;
    logic                k_max_hit;
    logic                k_sil_hit;
    logic                k_min_hit;

    // Configuration writes, accepted at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_thr <= ACT_RST;
            r_rel_thr <= REL_RST;
            r_sil_lim <= LIM_W'(64'(SIL_MS_RST) * 64'(SAMPLE_RATE));
            r_min_lim <= LIM_W'(64'(MIN_MS_RST) * 64'(SAMPLE_RATE));
            r_max_lim <= LIM_W'(64'(MAX_MS_RST) * 64'(SAMPLE_RATE));
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ACT: r_act_thr <= i_cfg_data[THR_W-1:0];
                CFG_REL: r_rel_thr <= i_cfg_data[THR_W-1:0];
                CFG_SIL: r_sil_lim <= LIM_W'(i_cfg_data[MS_W-1:0]) * LIM_W'(SAMPLE_RATE);
                CFG_MIN: r_min_lim <= LIM_W'(i_cfg_data[MS_W-1:0]) * LIM_W'(SAMPLE_RATE);
                CFG_MAX: r_max_lim <= LIM_W'(i_cfg_data) * LIM_W'(SAMPLE_RATE);
                default: ;
            endcase
        end
    end

    // Sample magnitude and saturating accumulate
    assign in_raw  = i_in.sample;
    assign in_mag  = in_raw[SAMPLE_W-1] ? (~in_raw + SAMPLE_W'(1)) : in_raw;
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
    assign n_sum   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    assign acc_sum = r_take ? n_sum : r_sum;

    // Threshold compares: 4*level against the larger scaled threshold
    assign lv4   = TH_W'({r_level, 2'b00});
    assign act_a = TH_W'(r_act_thr) * TH_W'(ACT_MUL);
    assign act_b = TH_W'(r_floor) * TH_W'(ACT_FLR);
    assign rel_a = TH_W'(r_rel_thr) * TH_W'(REL_MUL);
    assign rel_b = TH_W'(r_floor) * TH_W'(REL_FLR);
    assign loud  = (lv4 >= act_a) && (lv4 >= act_b);
    assign quiet = (lv4 < rel_a) || (lv4 < rel_b);

    // Saturating counter updates
    assign spk_ext = (CNTR_W + 1)'(r_spk) + (CNTR_W + 1)'(r_cnt);
    assign sil_ext = (CNTR_W + 1)'(r_sil) + (CNTR_W + 1)'(r_cnt);
    assign n_spk   = spk_ext[CNTR_W] ? '1 : spk_ext[CNTR_W-1:0];
    assign n_sil   = sil_ext[CNTR_W] ? '1 : sil_ext[CNTR_W-1:0];
    assign spoken  = (r_spk > r_sil) ? (r_spk - r_sil) : '0;

    // Noise floor average numerator, rounded by the bias
    assign floor_num = NUM_W'(r_floor) * NUM_W'(FLOOR_KEEP) + NUM_W'(r_level)
                       + NUM_W'(FLOOR_BIAS);

    // Shared count-to-duration scaler: count*1000 + 999 >= ms*rate
    // is the same test as count >= floor(ms*rate/1000)
    always_comb begin
        case (r_state)
            S_CMAX:  mul_src = r_sil;
            S_CSIL:  mul_src = r_spoken;
            default: mul_src = r_spk;
        endcase
    end

    assign k_val     = K_W'(mul_src) * K_W'(MS_PER_S) + K_W'(MS_PER_S - 1);
    assign k_max_hit = CMP_W'(r_k) >= CMP_W'(r_max_lim);
    assign k_sil_hit = CMP_W'(r_k) >= CMP_W'(r_sil_lim);
    assign k_min_hit = CMP_W'(r_k) >= CMP_W'(r_min_lim);

    // Divide / root unit requests
    always_comb begin
        du_cmd      = '0;
        du_dividend = {acc_sum, 2'b00};
        du_divisor  = r_cnt;
        case (r_state)
            S_ACC: begin
                du_cmd.start = r_last;
            end
            S_DIV: begin
                du_cmd.start     = du_stat.done;
                du_cmd.sqrt_mode = 1'b1;
                du_dividend      = du_res;
            end
            S_DECIDE: begin
                du_cmd.start = !r_speaking && !loud && (r_floor != '0);
                du_dividend  = DIVD_W'(floor_num);
                du_divisor   = CNT_W'(FLOOR_DIV);
            end
            default: ;
        endcase
    end

    evad_divsqrt #(
        .DVS_W (CNT_W)
    ) u_divsqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (du_cmd),
        .i_dividend (du_dividend),
        .i_divisor  (du_divisor),
        .o_stat     (du_stat),
        .o_result   (du_res)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sq        <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_over      <= 1'b0;
            r_take      <= 1'b0;
            r_last      <= 1'b0;
            r_level     <= '0;
            r_floor     <= '0;
            r_speaking  <= 1'b0;
            r_sil       <= '0;
            r_spk       <= '0;
            r_spoken    <= '0;
            r_quiet     <= 1'b0;
            r_k         <= '0;
            r_ev        <= EV_SILENCE;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            // result taken; the emit step reloads the register itself
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_last <= i_in.frame_last;
                        if (r_cnt < CNT_W'(MAX_FRAME)) begin
                            r_sq   <= SQ_W'(in_mag) * SQ_W'(in_mag);
                            r_cnt  <= r_cnt + CNT_W'(1);
                            r_take <= 1'b1;
                        end else begin
                            r_over <= 1'b1;
                            r_take <= 1'b0;
                        end
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum   <= acc_sum;
                    r_state <= r_last ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    if (du_stat.done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (du_stat.done) begin
                        r_level <= (|du_res[DIVD_W-1:LEVEL_W]) ? '1 : du_res[LEVEL_W-1:0];
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!r_speaking) begin
                        if (loud) begin
                            r_speaking <= 1'b1;
                            r_sil      <= '0;
                            r_spk      <= CNTR_W'(r_cnt);
                            r_ev       <= EV_START;
                            r_state    <= S_EMIT;
                        end else if (r_floor == '0) begin
                            r_floor <= r_level;
                            r_ev    <= EV_SILENCE;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_FLOOR;
                        end
                    end else begin
                        r_spk   <= n_spk;
                        r_sil   <= quiet ? n_sil : '0;
                        r_quiet <= quiet;
                        r_state <= S_PMAX;
                    end
                end
                S_FLOOR: begin
                    if (du_stat.done) begin
                        r_floor <= du_res[LEVEL_W-1:0];
                        r_ev    <= EV_SILENCE;
                        r_state <= S_EMIT;
                    end
                end
                S_PMAX: begin
                    r_k     <= k_val;
                    r_state <= S_CMAX;
                end
                // utterance length limit, then quiet tracking
                S_CMAX: begin
                    if (k_max_hit) begin
                        r_speaking <= 1'b0;
                        r_sil      <= '0;
                        r_ev       <= EV_ABORT;
                        r_state    <= S_EMIT;
                    end else if (!r_quiet) begin
                        r_ev    <= EV_SPEAKING;
                        r_state <= S_EMIT;
                    end else begin
                        r_k      <= k_val;
                        r_spoken <= spoken;
                        r_state  <= S_CSIL;
                    end
                end
                S_CSIL: begin
                    if (k_sil_hit) begin
                        r_k     <= k_val;
                        r_state <= S_CMIN;
                    end else begin
                        r_ev    <= EV_SPEAKING;
                        r_state <= S_EMIT;
                    end
                end
                // silence timeout reached: short utterances fall back to silence
                S_CMIN: begin
                    r_speaking <= 1'b0;
                    r_sil      <= '0;
                    if (!k_min_hit) begin
                        r_spk <= '0;
                        r_ev  <= EV_SILENCE;
                    end else begin
                        r_ev <= EV_END;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid          <= 1'b1;
                        r_out.vad_event      <= r_ev;
                        r_out.frame_level    <= r_level;
                        r_out.frame_overflow <= r_over;
                        r_sum                <= '0;
                        r_cnt                <= '0;
                        r_over               <= 1'b0;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    `EVAD_ASSERT_NXT(a_emit_clears_frame, (r_state == S_EMIT) && (!r_out_valid || !i_out_stall), (r_state == S_IDLE) && r_out_valid && (r_cnt == '0) && !r_over)
    `EVAD_ASSERT_IMP(a_silence_only_speaking, r_sil != '0, r_speaking)
    `EVAD_ASSERT_IMP(a_done_while_waiting, du_stat.done, (r_state == S_DIV) || (r_state == S_SQRT) || (r_state == S_FLOOR))
    `EVAD_ASSERT_IMP(a_start_when_free, du_cmd.start, !du_stat.busy)
    `EVAD_ASSERT_IMP(a_floor_moves_silent, r_floor != $past(r_floor), !$past(r_speaking))

endmodule

/* design/evad_divsqrt.sv */
// Shared radix-2 divider and digit-by-digit square root, one step per cycle.
module evad_divsqrt #(
    parameter int DVS_W = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  evad_pkg::t_du_cmd           i_cmd,
    input  logic [evad_pkg::DIVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]            i_divisor,
    output evad_pkg::t_du_stat          o_stat,
    output logic [evad_pkg::DIVD_W-1:0] o_result
);
    import evad_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic               r_busy;
    logic               r_done;
    logic               r_sqrt;
    logic [STEP_W-1:0]  r_steps;
    logic [DIVD_W-1:0]  r_src;
    logic [REM_W-1:0]   r_rem;
    logic [DIVD_W-1:0]  r_res;
    logic [DVS_W-1:0]   r_dvs;

    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic               fits;

    // One shared shift / compare / subtract step
    always_comb begin
        if (r_sqrt) begin
            rem_sh = {r_rem[REM_W-3:0], r_src[DIVD_W-1 -: 2]};
            trial  = {r_res[REM_W-3:0], 2'b01};
        end else begin
            rem_sh = {r_rem[REM_W-2:0], r_src[DIVD_W-1]};
            trial  = REM_W'(r_dvs);
        end
        fits = (rem_sh >= trial);
    end

    // Step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_steps <= i_cmd.sqrt_mode ? STEP_W'(DIVD_W / 2) : STEP_W'(DIVD_W);
            end else if (r_busy) begin
                r_steps <= r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sqrt <= i_cmd.sqrt_mode;
            r_src  <= i_dividend;
            r_rem  <= '0;
            r_res  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_src <= r_sqrt ? {r_src[DIVD_W-3:0], 2'b00} : {r_src[DIVD_W-2:0], 1'b0};
            r_rem <= fits ? (rem_sh - trial) : rem_sh;
            r_res <= {r_res[DIVD_W-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_res;

endmodule
